// ===== sv/lcdnw_pkg.sv =====
`timescale 1ns / 1ps

package lcdnw_pkg;

  // Default width of the tick counter.
  localparam int unsigned CountWidthDefault = 16;

  localparam int unsigned RegWidth = 16;

  // Register reset values, in ticks.
  localparam logic [RegWidth-1:0] InitPulseReset  = 16'd8;
  localparam logic [RegWidth-1:0] WritePulseReset = 16'd1600;
  localparam logic [RegWidth-1:0] ShortWaitReset  = 16'd1600;
  localparam logic [RegWidth-1:0] LongWaitReset   = 16'd40000;

  // Nibbles strobed by the init sequence: three function-set nibbles, then 4-bit mode.
  localparam logic [3:0] InitNibbleFuncSet = 4'h3;
  localparam logic [3:0] InitNibbleFourBit = 4'h2;

  // Beat widths on the stream ports.
  localparam int unsigned InTdataWidth  = 8;
  localparam int unsigned InTuserWidth  = 3;
  localparam int unsigned OutTdataWidth = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_INIT_PULSE  = 2'd0,
    CFG_WRITE_PULSE = 2'd1,
    CFG_SHORT_WAIT  = 2'd2,
    CFG_LONG_WAIT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RegWidth-1:0] init_pulse;
    logic [RegWidth-1:0] write_pulse;
    logic [RegWidth-1:0] short_wait;
    logic [RegWidth-1:0] long_wait;
  } cfg_t;

  typedef struct packed {
    logic       request_taken;
    logic       busy_res;
    logic       led;
    logic [3:0] data_nibble;
    logic       enable;
    logic       rs;
  } result_t;

endpackage

// ===== sv/lcdnw_cfg_regs.sv =====
`timescale 1ns / 1ps

module lcdnw_cfg_regs
  import lcdnw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [1:0]    wr_index_i,
  input  logic [RegWidth-1:0] wr_data_i,
  output cfg_t          cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_INIT_PULSE:  cfg_d.init_pulse  = wr_data_i;
        CFG_WRITE_PULSE: cfg_d.write_pulse = wr_data_i;
        CFG_SHORT_WAIT:  cfg_d.short_wait  = wr_data_i;
        CFG_LONG_WAIT:   cfg_d.long_wait   = wr_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_pulse  <= InitPulseReset;
      cfg_q.write_pulse <= WritePulseReset;
      cfg_q.short_wait  <= ShortWaitReset;
      cfg_q.long_wait   <= LongWaitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/lcdnw_seq_core.sv =====
`timescale 1ns / 1ps

module lcdnw_seq_core
  import lcdnw_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fire_i,
  input  logic [1:0] op_i,
  input  logic [7:0] byte_i,
  input  logic       is_data_i,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PULSE = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             step_q, step_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0]             held_byte_q, held_byte_d;
  logic                   held_is_data_q, held_is_data_d;
  logic                   running_init_q, running_init_d;
  logic                   taken;

  logic [RegWidth-1:0] load_len;
  logic [RegWidth-1:0] load_len_m1;
  logic [31:0]         load_ext;
  logic                do_load;
  logic                last_step;

  // A zero length counts as one tick; the count loaded is length minus one.
  assign load_len_m1 = (load_len == '0) ? '0 : load_len - 1'b1;
  assign load_ext    = {{(32 - RegWidth){1'b0}}, load_len_m1};
  assign last_step   = running_init_q ? (step_q == 2'd3) : (step_q == 2'd1);

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cnt_d          = cnt_q;
    held_byte_d    = held_byte_q;
    held_is_data_d = held_is_data_q;
    running_init_d = running_init_q;
    taken          = 1'b0;
    do_load        = 1'b0;
    load_len       = cfg_i.write_pulse;

    if (fire_i) begin
      unique case (state_q)
        ST_IDLE: begin
          case (op_e'(op_i))
            OP_WRITE: begin
              held_byte_d    = byte_i;
              held_is_data_d = is_data_i;
              running_init_d = 1'b0;
              state_d        = ST_PULSE;
              step_d         = 2'd0;
              load_len       = cfg_i.write_pulse;
              do_load        = 1'b1;
              taken          = 1'b1;
            end
            OP_INIT: begin
              running_init_d = 1'b1;
              state_d        = ST_PULSE;
              step_d         = 2'd0;
              load_len       = cfg_i.init_pulse;
              do_load        = 1'b1;
              taken          = 1'b1;
            end
            default: ;
          endcase
        end
        ST_PULSE: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            state_d = ST_WAIT;
            do_load = 1'b1;
            if (running_init_q) begin
              load_len = (step_q == 2'd0 || step_q == 2'd3) ? cfg_i.long_wait
                                                            : cfg_i.short_wait;
            end else begin
              load_len = held_is_data_q ? cfg_i.short_wait : cfg_i.long_wait;
            end
          end
        end
        ST_WAIT: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else if (!last_step) begin
            state_d  = ST_PULSE;
            step_d   = step_q + 2'd1;
            do_load  = 1'b1;
            load_len = running_init_q ? cfg_i.init_pulse : cfg_i.write_pulse;
          end else begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
        default: state_d = ST_IDLE;
      endcase
      if (do_load) begin
        cnt_d = load_ext[COUNT_WIDTH-1:0];
      end
    end
  end

  // Pin levels after this beat follow from the next state.
  always_comb begin
    res_o.request_taken = taken;
    res_o.busy_res      = (state_d != ST_IDLE);
    res_o.enable        = (state_d == ST_PULSE);
    res_o.led           = (state_d == ST_PULSE) && !running_init_d;
    res_o.rs            = (state_d != ST_IDLE) && !running_init_d && held_is_data_d;
    if (state_d == ST_IDLE) begin
      res_o.data_nibble = running_init_d ? InitNibbleFourBit : held_byte_d[3:0];
    end else if (running_init_d) begin
      res_o.data_nibble = (step_d == 2'd3) ? InitNibbleFourBit : InitNibbleFuncSet;
    end else begin
      res_o.data_nibble = (step_d == 2'd0) ? held_byte_d[7:4] : held_byte_d[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      cnt_q          <= '0;
      held_byte_q    <= '0;
      held_is_data_q <= 1'b0;
      running_init_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      step_q         <= step_d;
      cnt_q          <= cnt_d;
      held_byte_q    <= held_byte_d;
      held_is_data_q <= held_is_data_d;
      running_init_q <= running_init_d;
    end
  end

  // The sequencer only advances on accepted beats.
  a_hold_without_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(state_q) && $stable(step_q) && $stable(cnt_q))
    else $error("sequencer moved without an accepted beat");

  a_count_down_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && state_q != ST_IDLE && cnt_q != '0) |=>
      (state_q == $past(state_q)) && (step_q == $past(step_q)))
    else $error("phase changed before its count ran out");

  a_write_two_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && !running_init_q) |-> (step_q[1] == 1'b0))
    else $error("byte write went past its second nibble");

  a_taken_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.request_taken |-> (fire_i && state_q == ST_IDLE))
    else $error("request taken while busy");

endmodule

// ===== sv/lcdnw_out_skid.sv =====
`timescale 1ns / 1ps

module lcdnw_out_skid
  import lcdnw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    m_valid_q;
  result_t m_data_q;
  logic    s_valid_q;
  result_t s_data_q;
  logic    in_fire;
  logic    out_fire;

  assign in_ready_o = !s_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = m_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (!m_valid_q || out_fire) begin
      if (s_valid_q) begin
        m_valid_q <= 1'b1;
        s_valid_q <= 1'b0;
      end else begin
        m_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!m_valid_q || out_fire) begin
      m_data_q <= s_valid_q ? s_data_q : in_data_i;
    end else if (in_fire) begin
      s_data_q <= in_data_i;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_data_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> m_valid_q)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && m_valid_q && !out_ready_i) |=> s_valid_q)
    else $error("beat accepted during stall was not parked");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !s_valid_q && !in_fire) |=> !m_valid_q)
    else $error("output stayed valid after its beat was taken");

endmodule

// ===== sv/char_lcd_nibble_write_sequencer.sv =====
`timescale 1ns / 1ps

// Sequencer for a character display on a 4-bit bus. Each input beat is one
// timing tick and may request a byte write (op 1) or the init sequence (op 2);
// each input beat yields exactly one output beat with the pin levels after that
// tick. One beat is taken every clock cycle: the tick logic is a single pass
// between the state registers and a two-entry output stage, so tready stays
// high while downstream keeps up and drops only when both output entries hold
// undelivered beats. Requests that arrive while a sequence runs are dropped and
// report request_taken low. The config channel is always ready; the user must
// write timing registers only while no sequence runs; the block does not check.
module char_lcd_nibble_write_sequencer
  import lcdnw_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [InTdataWidth-1:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic [InTuserWidth-1:0]  s_axis_tuser,  // [1:0] op, [2] is_data
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] rs, [1] enable, [5:2] data_nibble, [6] led, [7] busy_res,
  // [8] request_taken, [15:9] zero
  output logic [OutTdataWidth-1:0] m_axis_tdata,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [RegWidth-1:0]      cfg_data_i
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  lcdnw_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lcdnw_seq_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (in_fire),
    .op_i      (s_axis_tuser[1:0]),
    .byte_i    (s_axis_tdata[7:0]),
    .is_data_i (s_axis_tuser[2]),
    .res_o     (res)
  );

  lcdnw_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {{(OutTdataWidth - $bits(result_t)){1'b0}}, out_res};

endmodule

// ===== tb/tb_char_lcd_nibble_write_sequencer.sv =====
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer;
  import lcdnw_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [4:0] PhaseIdle = 5'd0;

  typedef struct {
    logic [1:0] op;
    logic [7:0] byte_value;
    logic       is_data;
  } tick_item_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;   // [7:0] byte_value
  logic [InTuserWidth-1:0]  s_axis_tuser = '0;   // [1:0] op, [2] is_data
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // [0] rs, [1] enable, [5:2] data_nibble, [6] led, [7] busy_res,
  // [8] request_taken, [15:9] zero
  logic [OutTdataWidth-1:0] m_axis_tdata;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  cfg_idx_e                 cfg_index_i = CFG_INIT_PULSE;
  logic [RegWidth-1:0]      cfg_data_i = '0;

  tick_item_t tick_queue[$];
  tick_item_t cur_beat;
  result_t    pin_levels_due[$];
  bit         idle_on = 1'b1;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         fail_count = 0;
  int         beats_checked = 0;
  int         writes_started = 0;
  int         inits_started = 0;
  int         requests_dropped = 0;
  int         reg_writes = 0;
  int         settings_used = 0;

  // Shadow of the sequencer: timing registers and sequence state.
  cfg_t        timing;
  logic [4:0]  seq_phase = PhaseIdle;
  logic [15:0] phase_count = '0;
  logic [7:0]  held_byte = '0;
  logic        held_is_data = 1'b0;
  logic        in_init = 1'b0;

  char_lcd_nibble_write_sequencer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // A length register of zero still gives a one-tick phase.
  function automatic logic [15:0] count_for(logic [15:0] len);
    return (len == 16'd0) ? 16'd0 : len - 16'd1;
  endfunction

  function automatic logic [15:0] pulse_len();
    return in_init ? timing.init_pulse : timing.write_pulse;
  endfunction

  function automatic logic [15:0] wait_len(int unsigned step);
    if (in_init) begin
      return (step == 0 || step == 3) ? timing.long_wait : timing.short_wait;
    end
    return held_is_data ? timing.short_wait : timing.long_wait;
  endfunction

  function automatic logic [3:0] nibble_for(int unsigned step);
    if (in_init) begin
      return (step == 3) ? InitNibbleFourBit : InitNibbleFuncSet;
    end
    return (step == 0) ? held_byte[7:4] : held_byte[3:0];
  endfunction

  // Advances the shadow sequencer by one tick and returns the pin levels after it.
  function automatic result_t advance_display(tick_item_t it);
    result_t     r;
    int unsigned step;
    int unsigned steps_in_seq;
    r = '0;
    steps_in_seq = in_init ? 4 : 2;
    if (seq_phase == PhaseIdle) begin
      if (it.op == OP_WRITE) begin
        held_byte = it.byte_value;
        held_is_data = it.is_data;
        in_init = 1'b0;
        seq_phase = 5'd1;
        phase_count = count_for(pulse_len());
        r.request_taken = 1'b1;
        writes_started++;
      end else if (it.op == OP_INIT) begin
        in_init = 1'b1;
        seq_phase = 5'd1;
        phase_count = count_for(pulse_len());
        r.request_taken = 1'b1;
        inits_started++;
      end
    end else begin
      if (it.op == OP_WRITE || it.op == OP_INIT) requests_dropped++;
      if (phase_count != 16'd0) begin
        phase_count--;
      end else begin
        step = (seq_phase - 5'd1) >> 1;
        if (seq_phase[0]) begin
          seq_phase++;
          phase_count = count_for(wait_len(step));
        end else if (step + 1 < steps_in_seq) begin
          seq_phase++;
          phase_count = count_for(pulse_len());
        end else begin
          seq_phase = PhaseIdle;
          phase_count = '0;
        end
      end
    end
    if (seq_phase != PhaseIdle) begin
      step = (seq_phase - 5'd1) >> 1;
      r.busy_res = 1'b1;
      r.enable = seq_phase[0];
      r.data_nibble = nibble_for(step);
      r.rs = !in_init && held_is_data;
      r.led = seq_phase[0] && !in_init;
    end else begin
      // The data lines keep the last nibble that was driven.
      r.data_nibble = in_init ? InitNibbleFourBit : held_byte[3:0];
    end
    return r;
  endfunction

  function automatic string pins_text(result_t p);
    return $sformatf("rs=%0d en=%0d nib=%h led=%0d busy=%0d taken=%0d",
                     p.rs, p.enable, p.data_nibble, p.led, p.busy_res, p.request_taken);
  endfunction

  task automatic check_pins(logic [OutTdataWidth-1:0] beat);
    result_t got;
    result_t want;
    got = result_t'(beat[8:0]);
    if (pin_levels_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] output beat with nothing expected: %s", $time, pins_text(got));
      end
    end else begin
      want = pin_levels_due.pop_front();
      if (got.rs != want.rs || got.enable != want.enable ||
          got.data_nibble != want.data_nibble || got.led != want.led ||
          got.busy_res != want.busy_res || got.request_taken != want.request_taken ||
          beat[15:9] != '0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] beat %0d mismatch: expected %s, got %s (tdata=%h)", $time,
                   beats_checked, pins_text(want), pins_text(got), beat);
        end
      end
    end
    beats_checked++;
  endtask

  // Input driver: presents queued ticks, predicts on every accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pin_levels_due.push_back(advance_display(cur_beat));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          cur_beat = tick_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur_beat.byte_value;
          s_axis_tuser <= {cur_beat.is_data, cur_beat.op};
          if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_pins(m_axis_tdata);
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 7);
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] byte_value, logic is_data);
    tick_item_t it;
    it.op = op;
    it.byte_value = byte_value;
    it.is_data = is_data;
    tick_queue.push_back(it);
  endtask

  task automatic push_random_ticks(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) push_item(OP_INIT, 8'($urandom), 1'($urandom));
      else if (pick < 24) push_item(OP_WRITE, 8'($urandom), 1'($urandom));
      else if (pick < 30) push_item(OpUnused, 8'($urandom), 1'($urandom));
      else push_item(OP_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  function automatic logic [15:0] rand_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'd0;
    if (pick < 14) return 16'($urandom_range(1, 4));
    return 16'($urandom_range(5, 12));
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_INIT_PULSE:  timing.init_pulse = val;
      CFG_WRITE_PULSE: timing.write_pulse = val;
      CFG_SHORT_WAIT:  timing.short_wait = val;
      default:         timing.long_wait = val;
    endcase
    reg_writes++;
  endtask

  task automatic write_timing(logic [15:0] ip, logic [15:0] wp, logic [15:0] sw,
                              logic [15:0] lw);
    write_reg(CFG_INIT_PULSE, ip);
    write_reg(CFG_WRITE_PULSE, wp);
    write_reg(CFG_SHORT_WAIT, sw);
    write_reg(CFG_LONG_WAIT, lw);
    settings_used++;
    @(negedge clk_i);
  endtask

  // Waits until every queued tick is accepted and every result is back.
  task automatic quiesce();
    while (tick_queue.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (pin_levels_due.size() != 0) @(negedge clk_i);
  endtask

  // Feeds ticks, some with the unused op, until the running sequence has ended.
  task automatic settle(int batch);
    quiesce();
    while (seq_phase != PhaseIdle) begin
      for (int i = 0; i < batch; i++) begin
        push_item(($urandom_range(0, 7) == 0) ? OpUnused : OP_TICK, 8'($urandom),
                  1'($urandom));
      end
      quiesce();
    end
  endtask

  initial begin
    timing.init_pulse = InitPulseReset;
    timing.write_pulse = WritePulseReset;
    timing.short_wait = ShortWaitReset;
    timing.long_wait = LongWaitReset;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every op, byte extremes, requests while busy and near the end.
    write_timing(16'd1, 16'd2, 16'd1, 16'd2);
    push_item(OP_TICK, 8'hFF, 1'b1);
    push_item(OpUnused, 8'h00, 1'b0);
    push_item(OP_INIT, 8'h00, 1'b0);
    push_item(OP_WRITE, 8'h81, 1'b0);
    push_item(OP_INIT, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) push_item(OP_TICK, 8'h00, 1'b0);
    push_item(OP_WRITE, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) push_item(OP_TICK, 8'hFF, 1'b1);
    push_item(OP_WRITE, 8'h00, 1'b0);
    push_item(OP_TICK, 8'h5A, 1'b0);
    push_item(OP_WRITE, 8'hA5, 1'b1);
    settle(16);

    for (int p = 0; p < 4; p++) begin
      idle_on = (p < 3);
      write_timing(rand_len(), rand_len(), rand_len(), rand_len());
      if (p == 1) begin
        push_random_ticks(210);
        quiesce();
        push_random_ticks(210);
      end else begin
        push_random_ticks(420);
      end
      settle(32);
    end

    // Full-scale values in the registers a data write does not use, longer ones in the rest.
    write_timing(16'hFFFF, 16'd40, 16'd24, 16'hFFFF);
    push_item(OP_WRITE, 8'hC3, 1'b1);
    push_item(OP_INIT, 8'h00, 1'b0);
    push_item(OP_WRITE, 8'h3C, 1'b0);
    settle(32);

    repeat (16) @(posedge clk_i);
    if (pin_levels_due.size() != 0) begin
      fail_count++;
      $display("%0d expected output beats never arrived", pin_levels_due.size());
    end
    $display("Checked %0d ticks: %0d byte writes and %0d init sequences started,",
             beats_checked, writes_started, inits_started);
    $display("%0d requests dropped while busy, %0d register writes over %0d settings.",
             requests_dropped, reg_writes, settings_used);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lcdnw_pkg.sv
sv/lcdnw_cfg_regs.sv
sv/lcdnw_seq_core.sv
sv/lcdnw_out_skid.sv
sv/char_lcd_nibble_write_sequencer.sv
tb/tb_char_lcd_nibble_write_sequencer.sv
